FILE: rtl/tmrbank_pkg.sv
package tmrbank_pkg;

	// request kinds
	localparam logic [2:0] REQ_TICK          = 3'd0;
	localparam logic [2:0] REQ_START_PERIOD  = 3'd1;
	localparam logic [2:0] REQ_END_PERIOD    = 3'd2;
	localparam logic [2:0] REQ_POLL_PERIOD   = 3'd3;
	localparam logic [2:0] REQ_START_TIMEOUT = 3'd4;
	localparam logic [2:0] REQ_POLL_TIMEOUT  = 3'd5;

	localparam int unsigned CNT_W = 16;

	typedef struct packed {
		logic [2:0]       req_type;
		logic [2:0]       channel;
		logic [CNT_W-1:0] load_value;
	} request_t;

	typedef struct packed {
		logic done_res;
		logic bad_index;
	} result_t;

	// per-channel command, one cycle wide
	typedef struct packed {
		logic             tick;
		logic             load;
		logic             stop;
		logic             poll;
		logic [CNT_W-1:0] value;
	} chan_cmd_t;

endpackage

FILE: rtl/tmrbank_period_chan.sv
module tmrbank_period_chan (
	input  logic                  clk,
	input  logic                  arst_n,
	input  tmrbank_pkg::chan_cmd_t cmd,
	output logic                  completed
);
	import tmrbank_pkg::*;

	logic             active_q;
	logic             completed_q;
	logic [CNT_W-1:0] reload_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_dec;

	// wraps from zero to all ones, as intended
	assign count_dec = count_q - CNT_W'(1);
	assign completed = completed_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			completed_q <= 1'b0;
			reload_q    <= '0;
			count_q     <= '0;
		end else begin
			priority if (cmd.load) begin
				active_q    <= 1'b1;
				completed_q <= 1'b0;
				reload_q    <= cmd.value;
				count_q     <= cmd.value;
			end else if (cmd.stop) begin
				active_q <= 1'b0;
			end else if (cmd.poll) begin
				completed_q <= 1'b0;
			end else if (cmd.tick && active_q) begin
				if (count_dec == '0) begin
					completed_q <= 1'b1;
					count_q     <= reload_q;
				end else begin
					count_q <= count_dec;
				end
			end
		end
	end

endmodule

FILE: rtl/tmrbank_timeout_chan.sv
module tmrbank_timeout_chan (
	input  logic                  clk,
	input  logic                  arst_n,
	input  tmrbank_pkg::chan_cmd_t cmd,
	output logic                  expired
);
	import tmrbank_pkg::*;

	logic [CNT_W-1:0] count_q;

	assign expired = (count_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			priority if (cmd.load) begin
				count_q <= cmd.value;
			end else if (cmd.tick && !expired) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

FILE: rtl/period_and_timeout_timer_bank.sv
// Bank of periodic timers and one-shot timeouts. A request is taken on any
// clock edge with start high; busy is never raised, so one request per cycle is
// sustained. Every request returns exactly one result, marked by result_strobe
// for a single cycle once the request has passed the input register, decode and
// channel update, and the result register. The receiver cannot stall: a result
// not captured in its strobe cycle is gone. A tick advances every active period
// channel and every unexpired timeout channel at once; a poll of a period clears
// its completed flag. A channel index beyond the channel count of its kind sets
// bad_index and leaves all state alone.
module period_and_timeout_timer_bank #(
	parameter int unsigned PERIOD_CHANNELS  = 4,
	parameter int unsigned TIMEOUT_CHANNELS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  tmrbank_pkg::request_t request,
	output logic                  result_strobe,
	output tmrbank_pkg::result_t  result
);
	import tmrbank_pkg::*;

	// channel counts as 4-bit values for the range check
	localparam logic [3:0] PER_N = 4'(PERIOD_CHANNELS);
	localparam logic [3:0] TOUT_N = 4'(TIMEOUT_CHANNELS);

	// input register
	logic     valid_s1;
	request_t req_s1;

	// result register
	logic    strobe_s2;
	result_t result_s2;

	// decode
	logic    per_ok;
	logic    tout_ok;
	logic    do_tick;
	logic    per_load;
	logic    per_stop;
	logic    per_poll;
	logic    tout_load;
	logic    tout_poll;
	result_t result_d;

	logic [PERIOD_CHANNELS-1:0]  per_sel;
	logic [PERIOD_CHANNELS-1:0]  per_completed;
	logic [TIMEOUT_CHANNELS-1:0] tout_sel;
	logic [TIMEOUT_CHANNELS-1:0] tout_expired;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			req_s1 <= request;
		end
	end

	assign per_ok  = {1'b0, req_s1.channel} < PER_N;
	assign tout_ok = {1'b0, req_s1.channel} < TOUT_N;

	always_comb begin
		do_tick   = 1'b0;
		per_load  = 1'b0;
		per_stop  = 1'b0;
		per_poll  = 1'b0;
		tout_load = 1'b0;
		tout_poll = 1'b0;
		result_d  = '0;
		if (valid_s1) begin
			unique case (req_s1.req_type)
				REQ_TICK: begin
					do_tick = 1'b1;
				end
				REQ_START_PERIOD: begin
					per_load           = per_ok;
					result_d.bad_index = !per_ok;
				end
				REQ_END_PERIOD: begin
					per_stop           = per_ok;
					result_d.bad_index = !per_ok;
				end
				REQ_POLL_PERIOD: begin
					per_poll           = per_ok;
					result_d.bad_index = !per_ok;
				end
				REQ_START_TIMEOUT: begin
					tout_load          = tout_ok;
					result_d.bad_index = !tout_ok;
				end
				REQ_POLL_TIMEOUT: begin
					tout_poll          = tout_ok;
					result_d.bad_index = !tout_ok;
				end
				default: begin
					// unused request codes: no effect
				end
			endcase
		end
		// the select vectors are one-hot, so an OR picks the addressed channel
		if (per_poll) begin
			result_d.done_res = |(per_completed & per_sel);
		end else if (tout_poll) begin
			result_d.done_res = |(tout_expired & tout_sel);
		end
	end

	// periodic channels
	for (genvar k = 0; k < PERIOD_CHANNELS; k++) begin : g_period
		chan_cmd_t cmd;

		assign per_sel[k] = (req_s1.channel == 3'(k));
		assign cmd.tick   = do_tick;
		assign cmd.load   = per_load && per_sel[k];
		assign cmd.stop   = per_stop && per_sel[k];
		assign cmd.poll   = per_poll && per_sel[k];
		assign cmd.value  = req_s1.load_value;

		tmrbank_period_chan u_chan (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd),
			.completed (per_completed[k])
		);
	end

	// timeout channels
	for (genvar k = 0; k < TIMEOUT_CHANNELS; k++) begin : g_timeout
		chan_cmd_t cmd;

		assign tout_sel[k] = (req_s1.channel == 3'(k));
		assign cmd.tick    = do_tick;
		assign cmd.load    = tout_load && tout_sel[k];
		assign cmd.stop    = 1'b0;
		assign cmd.poll    = 1'b0;
		assign cmd.value   = req_s1.load_value;

		tmrbank_timeout_chan u_chan (
			.clk     (clk),
			.arst_n  (arst_n),
			.cmd     (cmd),
			.expired (tout_expired[k])
		);
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_s2 <= 1'b0;
		end else begin
			strobe_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		result_s2 <= result_d;
	end

	assign result_strobe = strobe_s2;
	assign result        = result_s2;

	// every taken request yields one result
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> ##1 result_strobe)
		else $error("request without result");

	// no result appears without a request behind it
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> $past(valid_s1))
		else $error("result without request");

	// a bad index never reports done
	a_bad_not_done: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> !(result.done_res && result.bad_index))
		else $error("done and bad_index both set");

	// a tick returns a clear result
	a_tick_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && req_s1.req_type == REQ_TICK)
			|=> (result_strobe && !result.done_res && !result.bad_index))
		else $error("tick gave non-zero result");

endmodule
